[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skip while reset is high.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_CLKD_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/mavf_pkg.sv]
// ----------------------------------------------------------------------------
// mavf_pkg
// Types and fixed constants of the moving average filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mavf_pkg;

   localparam int SAMPLE_W = 32;   // sample and average width
   localparam int CSR_W    = 7;    // window length register width

   localparam logic [CSR_W-1:0] LEN_RESET = CSR_W'(16);

   // status of the bit-serial divider
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

[hdl/mavf_window.sv]
// ----------------------------------------------------------------------------
// mavf_window
// Window store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mavf_window #(
   parameter int DEPTH  = 64,
   parameter int IDX_W  = 6
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [IDX_W-1:0]              wr_addr,
   input  wire logic [mavf_pkg::SAMPLE_W-1:0] wr_data,
   input  wire logic                          rd_en,
   input  wire logic [IDX_W-1:0]              rd_addr,
   output logic [mavf_pkg::SAMPLE_W-1:0]      rd_data
);

   logic [mavf_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic [mavf_pkg::SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/mavf_serial_div.sv]
// ----------------------------------------------------------------------------
// mavf_serial_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
`default_nettype none

module mavf_serial_div #(
   parameter int SUM_W = 39,
   parameter int DIV_W = 7
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [SUM_W-1:0]   dividend,
   input  wire logic [DIV_W-1:0]   divisor,
   output logic [SUM_W-1:0]        quotient,
   output mavf_pkg::div_status_type status
);

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] quo_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] dvs_ff;
   logic [CNT_W-1:0] count_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DIV_W:0]   trial;
   logic             fits;

   // shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         // pulse done on the cycle after the last quotient bit
         done_ff <= !start && busy_ff && (count_ff == CNT_W'(1));
         if (start) begin
            quo_ff   <= dividend;
            rem_ff   <= '0;
            dvs_ff   <= divisor;
            count_ff <= CNT_W'(SUM_W);
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            quo_ff   <= {quo_ff[SUM_W-2:0], fits};
            rem_ff   <= fits ? DIV_W'(trial - {1'b0, dvs_ff}) : DIV_W'(trial);
            count_ff <= count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

[hdl/moving_average_filter_unit.sv]
// ----------------------------------------------------------------------------
// moving_average_filter_unit
// Boxcar moving average with a bit-serial divider.
// ----------------------------------------------------------------------------
// Each item carries one signed sample. The block returns
// (sample + sum of the last window_length stored samples) / (window_length+1),
// truncated toward zero, then stores the sample in the ring over the oldest
// entry. One item is in flight at a time; it passes the load, setup, divide
// and finish states before its result turns valid; SUM_W, the width of the
// running sum, is 32 + clog2(MAX_WINDOW+1). The bit-serial restoring divider,
// which retires one quotient bit per cycle, takes up most of the time per
// item. A new item is taken while the last result still waits on the
// response side; the one after it stalls until that result goes.
// Writing window_length (0 reads as 1, values above MAX_WINDOW saturate) also
// empties the window; the length after reset is 16, or MAX_WINDOW if smaller.
// There is no clearing pass after reset: a fill flag marks the ring as holding
// zeros until every entry of the current window was written.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_filter_unit #(
   parameter int MAX_WINDOW = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [mavf_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [mavf_pkg::SAMPLE_W-1:0]      rsp_average,
   input  wire logic                                 csr_wr_en,
   input  wire logic [mavf_pkg::CSR_W-1:0]           csr_wr_data
);

   localparam int SW    = mavf_pkg::SAMPLE_W;
   localparam int LEN_W = mavf_pkg::CSR_W;
   localparam int IDX_W = $clog2(MAX_WINDOW);
   localparam int SUM_W = SW + $clog2(MAX_WINDOW + 1);
   localparam int DIV_W = $clog2(MAX_WINDOW + 2);
   localparam int CMP_W = IDX_W + LEN_W + 1;

   // reset length, held within the ring size
   localparam logic [LEN_W-1:0] LEN_START =
      (MAX_WINDOW < int'(mavf_pkg::LEN_RESET)) ? LEN_W'(MAX_WINDOW) : mavf_pkg::LEN_RESET;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SETUP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type                state_ff;
   logic signed [SW-1:0]     sample_ff;
   logic [IDX_W-1:0]         next_ff;
   logic [IDX_W-1:0]         wi_ff;
   logic [LEN_W-1:0]         len_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  dividend_ff;
   logic [SW-1:0]            old_ff;
   logic                     neg_ff;
   logic                     full_ff;
   logic                     rsp_valid_ff;
   logic signed [SW-1:0]     rsp_average_ff;

   logic [LEN_W-1:0]         len_in;
   logic [CMP_W-1:0]         wi_inc;
   logic [IDX_W-1:0]         next_in;
   logic                     accept;
   logic [SUM_W-1:0]         div_dividend;
   logic [DIV_W-1:0]         div_divisor;
   logic [SUM_W-1:0]         div_quotient;
   mavf_pkg::div_status_type div_status;
   logic [SW-1:0]            rd_data;
   logic [SW-1:0]            quo_low;

   // clamp the written length into 1..MAX_WINDOW
   always_comb begin
      if (csr_wr_data == '0) begin
         len_in = LEN_W'(1);
      end else if (CMP_W'(csr_wr_data) > CMP_W'(MAX_WINDOW)) begin
         len_in = LEN_W'(MAX_WINDOW);
      end else begin
         len_in = csr_wr_data;
      end
   end

   // advance the write index modulo the window length
   assign wi_inc  = CMP_W'(wi_ff) + CMP_W'(1);
   assign next_in = (wi_inc == CMP_W'(len_ff)) ? '0 : IDX_W'(wi_inc);

   assign req_ready = (state_ff == ST_IDLE) && !div_status.busy;
   assign accept    = req_valid && req_ready;

   // divide magnitudes, fix the sign afterwards (truncation toward zero)
   assign div_dividend = dividend_ff[SUM_W-1] ? SUM_W'(-dividend_ff) : SUM_W'(dividend_ff);
   assign div_divisor  = DIV_W'(len_ff) + DIV_W'(1);
   assign quo_low      = div_quotient[SW-1:0];

   mavf_window #(
      .DEPTH (MAX_WINDOW),
      .IDX_W (IDX_W)
   ) u_window (
      .clock   (clock),
      .wr_en   (state_ff == ST_SETUP),
      .wr_addr (next_ff),
      .wr_data (sample_ff),
      .rd_en   (accept),
      .rd_addr (next_in),
      .rd_data (rd_data)
   );

   mavf_serial_div #(
      .SUM_W (SUM_W),
      .DIV_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_SETUP),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wi_ff        <= '0;
         len_ff       <= LEN_START;
         sum_ff       <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the result once the consumer takes it, unless a new one lands
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  sample_ff <= req_sample;
                  next_ff   <= next_in;
                  state_ff  <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               // an entry not yet written in this window reads as zero
               old_ff      <= full_ff ? rd_data : '0;
               dividend_ff <= sum_ff + {{(SUM_W-SW){sample_ff[SW-1]}}, sample_ff};
               state_ff    <= ST_SETUP;
            end
            ST_SETUP: begin
               // retire the oldest entry from the running sum, store the sample
               sum_ff   <= dividend_ff - {{(SUM_W-SW){old_ff[SW-1]}}, old_ff};
               neg_ff   <= dividend_ff[SUM_W-1];
               wi_ff    <= next_ff;
               if (next_ff == '0) begin
                  full_ff <= 1'b1;
               end
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (div_status.done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_average_ff <= neg_ff ? -quo_low : quo_low;
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         // a length write empties the window
         if (csr_wr_en) begin
            len_ff  <= len_in;
            wi_ff   <= '0;
            sum_ff  <= '0;
            full_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

endmodule

`default_nettype wire

[hdl/mavf_checker.sv]
// ----------------------------------------------------------------------------
// mavf_checker
// Port-level checks of the moving average filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mavf_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [mavf_pkg::SAMPLE_W-1:0] rsp_average
);

   `ASSERT_CLKD(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average), "result item changed before it was taken")
   `ASSERT_CLKD(a_one_in_flight, clock, reset, req_valid && req_ready |=> !req_ready, "second item taken while one is in flight")
   `ASSERT_CLKD(a_no_early_rsp, clock, reset, req_valid && req_ready && !rsp_valid |=> !rsp_valid, "result item appeared right after acceptance")
   `ASSERT_CLKD_ALWAYS(a_reset_state, clock, reset |=> !rsp_valid && req_ready, "block not idle after reset")

endmodule

bind moving_average_filter_unit mavf_checker u_mavf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_average (rsp_average)
);

`default_nettype wire
